[design/ihex_pkg.sv]
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, character codes and the hex digit decoder for the Intel HEX
// record parser.
// ----------------------------------------------------------------------------
package ihex_pkg;

    // Parser phase, one-hot coded.
    typedef enum logic [6:0] {
        PH_START = 7'b0000001,
        PH_SKIP  = 7'b0000010,
        PH_COUNT = 7'b0000100,
        PH_ADDR  = 7'b0001000,
        PH_TYPE  = 7'b0010000,
        PH_DATA  = 7'b0100000,
        PH_CSUM  = 7'b1000000
    } t_phase;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // Character codes the parser reacts to.
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    // Reset value of the data-only filter.
    localparam logic DATA_ONLY_RESET = 1'b1;

    // Parser state carried from one character to the next.
    typedef struct packed {
        t_phase      phase;
        logic [1:0]  digit_count;
        logic [3:0]  high_nibble;
        logic [7:0]  count_held;
        logic [15:0] address_held;
        logic [7:0]  type_held;
        logic [7:0]  byte_index;
        logic [7:0]  running_sum;
    } t_state;

    // One result item.
    typedef struct packed {
        t_kind       kind;
        logic [15:0] address;
        logic [7:0]  data_byte;
        logic [7:0]  record_type;
        logic [7:0]  byte_count;
        logic [7:0]  checksum_read;
        logic        checksum_ok;
    } t_result;

    // Hex digit value; anything that is not a hex digit counts as zero.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

[design/ihex_char_if.sv]
// ----------------------------------------------------------------------------
// ihex_char_if
// Character input channel: one ASCII character per transfer.
// ----------------------------------------------------------------------------
interface ihex_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

[design/ihex_cfg_if.sv]
// ----------------------------------------------------------------------------
// ihex_cfg_if
// Configuration write channel for the data-only filter register.
// ----------------------------------------------------------------------------
interface ihex_cfg_if;
    logic valid;
    logic ready;
    logic data_only;

    modport source (output valid, output data_only, input ready);
    modport sink   (input valid, input data_only, output ready);
endinterface

[design/ihex_res_if.sv]
// ----------------------------------------------------------------------------
// ihex_res_if
// Result channel: data bytes, record ends and format errors.
// ----------------------------------------------------------------------------
interface ihex_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic [7:0]  record_type;
    logic [7:0]  byte_count;
    logic [7:0]  checksum_read;
    logic        checksum_ok;

    modport source (output valid, output kind, output address, output data_byte,
                    output record_type, output byte_count, output checksum_read,
                    output checksum_ok, input ready);
    modport sink   (input valid, input kind, input address, input data_byte,
                    input record_type, input byte_count, input checksum_read,
                    input checksum_ok, output ready);
endinterface

[design/ihex_step.sv]
// ----------------------------------------------------------------------------
// ihex_step
// Next-state and result logic for one character of the hex text stream.
// ----------------------------------------------------------------------------
module ihex_step (
    input  ihex_pkg::t_state  i_state,
    input  logic [7:0]        i_char,
    input  logic              i_data_only,
    output ihex_pkg::t_state  o_state,
    output logic              o_res_valid,
    output ihex_pkg::t_result o_result
);
    import ihex_pkg::*;

    logic [3:0]  nib;
    logic [7:0]  byte_val;
    logic [15:0] addr_shift;
    logic [7:0]  idx_next;
    logic [7:0]  sum_byte;

    // Datapath pieces shared by the phases.
    always_comb begin
        nib        = nibble_of(i_char);
        byte_val   = {i_state.high_nibble, nib};
        addr_shift = {i_state.address_held[11:0], nib};
        idx_next   = i_state.byte_index + 8'd1;
        sum_byte   = i_state.running_sum + byte_val;
    end

    // Phase handling.
    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_result    = '0;

        if (i_state.phase == PH_START) begin
            if (i_char == CH_LF || i_char == CH_CR || i_char == CH_SPACE ||
                i_char == CH_TAB) begin
                o_state = i_state;
            end else if (i_char == CH_SEMI) begin
                o_state.phase = PH_SKIP;
            end else if (i_char == CH_COLON) begin
                o_state       = '0;
                o_state.phase = PH_COUNT;
            end else begin
                // Bad line start: report it and skip the rest of the line.
                o_state.phase = PH_SKIP;
                o_res_valid   = 1'b1;
                o_result.kind = KIND_ERR;
            end
        end else if (i_char == CH_LF) begin
            // Line feed ends the line; an unfinished record is dropped.
            o_state.phase = PH_START;
        end else begin
            case (i_state.phase)
                PH_ADDR: begin
                    o_state.address_held = addr_shift;
                    if (i_state.digit_count[0]) begin
                        o_state.running_sum = i_state.running_sum + addr_shift[7:0];
                    end
                    if (i_state.digit_count == 2'd3) begin
                        o_state.digit_count = 2'd0;
                        o_state.phase       = PH_TYPE;
                    end else begin
                        o_state.digit_count = i_state.digit_count + 2'd1;
                    end
                end
                PH_COUNT, PH_TYPE, PH_DATA, PH_CSUM: begin
                    if (i_state.digit_count == 2'd0) begin
                        o_state.high_nibble = nib;
                        o_state.digit_count = 2'd1;
                    end else begin
                        o_state.digit_count = 2'd0;
                        case (i_state.phase)
                            PH_COUNT: begin
                                o_state.count_held  = byte_val;
                                o_state.running_sum = sum_byte;
                                o_state.phase       = PH_ADDR;
                            end
                            PH_TYPE: begin
                                o_state.type_held   = byte_val;
                                o_state.running_sum = sum_byte;
                                o_state.byte_index  = 8'd0;
                                o_state.phase = (i_state.count_held == 8'd0) ?
                                                PH_CSUM : PH_DATA;
                            end
                            PH_DATA: begin
                                o_state.running_sum = sum_byte;
                                o_state.byte_index  = idx_next;
                                if (idx_next == i_state.count_held) begin
                                    o_state.phase = PH_CSUM;
                                end
                                o_res_valid = (i_state.type_held == 8'd0) || !i_data_only;
                                o_result.kind        = KIND_DATA;
                                o_result.address     = i_state.address_held +
                                                       {8'd0, i_state.byte_index};
                                o_result.data_byte   = byte_val;
                                o_result.record_type = i_state.type_held;
                                o_result.byte_count  = i_state.count_held;
                            end
                            default: begin
                                // Checksum byte closes the record.
                                o_state.phase          = PH_SKIP;
                                o_res_valid            = 1'b1;
                                o_result.kind          = KIND_END;
                                o_result.address       = i_state.address_held;
                                o_result.record_type   = i_state.type_held;
                                o_result.byte_count    = i_state.count_held;
                                o_result.checksum_read = byte_val;
                                o_result.checksum_ok   = (sum_byte == 8'd0);
                            end
                        endcase
                    end
                end
                default: begin
                    // Skipping to line feed; unused codes do the same.
                    o_state = i_state;
                end
            endcase
        end
    end

endmodule

[design/ihex_skid.sv]
// ----------------------------------------------------------------------------
// ihex_skid
// Two-entry result buffer: an output register backed by a skid register, so
// a new character can be taken while a finished result still waits.
// ----------------------------------------------------------------------------
module ihex_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    input  ihex_pkg::t_result i_push_data,
    output logic              o_space,
    ihex_res_if.source        o_out
);
    import ihex_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    out_fire;

    assign out_fire = r_main_valid && o_out.ready;
    assign o_space  = !r_skid_valid;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push_valid) begin
            if (!r_main_valid || out_fire) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_main_valid <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_main <= r_skid;
            end
        end else if (i_push_valid) begin
            if (!r_main_valid || out_fire) begin
                r_main <= i_push_data;
            end else begin
                r_skid <= i_push_data;
            end
        end
    end

    // Output channel.
    assign o_out.valid         = r_main_valid;
    assign o_out.kind          = r_main.kind;
    assign o_out.address       = r_main.address;
    assign o_out.data_byte     = r_main.data_byte;
    assign o_out.record_type   = r_main.record_type;
    assign o_out.byte_count    = r_main.byte_count;
    assign o_out.checksum_read = r_main.checksum_read;
    assign o_out.checksum_ok   = r_main.checksum_ok;

`ifndef SYNTH
    // The skid entry is only ever filled behind a waiting output entry.
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry holds a result while the output entry is empty");

    // No result arrives while both entries are occupied.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_valid |-> !r_skid_valid)
        else $error("result pushed into a full buffer");

    // When the output transfer completes with the skid full, the skid moves up.
    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && out_fire) |=> (r_main_valid && r_main == $past(r_skid)))
        else $error("skid entry lost on output transfer");
`endif

endmodule

[design/intel_hex_record_parser_top.sv]
// ----------------------------------------------------------------------------
// intel_hex_record_parser_top
// A result is registered into the result buffer on the transfer of the
// character that causes it. Throughput: one character per cycle while the
// result buffer has space; the two-entry result buffer keeps input flowing
// for one stalled result. Reset (synchronous, active low) returns the parser
// to line start, empties the result buffer and sets the data-only filter to 1.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ihex_char_if.sink  i_char,
    ihex_cfg_if.sink   i_cfg,
    ihex_res_if.source o_result
);
    import ihex_pkg::*;

    t_state  r_state;
    t_state  n_state;
    logic    r_data_only;
    logic    step_valid;
    t_result step_result;
    logic    buf_space;
    logic    char_fire;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_only <= DATA_ONLY_RESET;
        end else if (i_cfg.valid) begin
            r_data_only <= i_cfg.data_only;
        end
    end

    // Character transfer.
    assign i_char.ready = buf_space;
    assign char_fire    = i_char.valid && buf_space;

    ihex_step u_step (
        .i_state     (r_state),
        .i_char      (i_char.char_in),
        .i_data_only (r_data_only),
        .o_state     (n_state),
        .o_res_valid (step_valid),
        .o_result    (step_result)
    );

    // Parser state advances on each character transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_START, digit_count: 2'd0, high_nibble: 4'd0,
                         count_held: 8'd0, address_held: 16'd0, type_held: 8'd0,
                         byte_index: 8'd0, running_sum: 8'd0};
        end else if (char_fire) begin
            r_state <= n_state;
        end
    end

    ihex_skid u_skid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (char_fire && step_valid),
        .i_push_data  (step_result),
        .o_space      (buf_space),
        .o_out        (o_result)
    );

endmodule

[tb/sv/tb_intel_hex_record_parser_top.sv]
// ----------------------------------------------------------------------------
// tb_intel_hex_record_parser_top
// Self-checking testbench for the Intel HEX record parser. A short table of
// characters covers line-start handling, format errors, comments, a record at
// the top of the address space and a record cut short by a line feed. Random
// lines of well-formed records, mixed with comments, bad lines and noise,
// follow under both settings of the data-only filter. Every result transfer
// is checked field by field against a cycle-free parser model kept in the
// testbench, or against the hand-written result of a typed directed row.
// ----------------------------------------------------------------------------
module tb_intel_hex_record_parser_top;
    import ihex_pkg::*;

    // One row of character stimulus; typed rows carry a hand-written result.
    typedef struct packed {
        logic [7:0] c;
        logic       typed;
        t_result    want;
    } t_char_row;

    localparam t_result NO_RESULT = '0;
    localparam t_result BAD_START = {KIND_ERR, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0};
    localparam t_result TOP_BYTE  = {KIND_DATA, 16'hFFFF, 8'hAB, 8'h00, 8'h01, 8'h00, 1'b0};
    localparam t_result TOP_END   = {KIND_END, 16'hFFFF, 8'h00, 8'h00, 8'h01, 8'h56, 1'b1};
    localparam int      RANDOM_PER_SETTING = 225;

    logic i_clk;
    logic i_rst_n;

    ihex_char_if char_if ();
    ihex_cfg_if  cfg_if ();
    ihex_res_if  res_if ();

    intel_hex_record_parser_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    // Directed characters: blanks, empty line, bad starts, a comment holding a
    // colon, a record at address 0xFFFF, trailing text and a truncated record.
    t_char_row directed_rows [29] = '{
        {CH_SPACE, 1'b0, NO_RESULT}, {CH_CR, 1'b0, NO_RESULT},
        {CH_TAB, 1'b0, NO_RESULT},   {CH_LF, 1'b0, NO_RESULT},
        {"X", 1'b1, BAD_START},      {CH_LF, 1'b0, NO_RESULT},
        {CH_SEMI, 1'b0, NO_RESULT},  {CH_COLON, 1'b0, NO_RESULT},
        {CH_LF, 1'b0, NO_RESULT},    {8'hFF, 1'b1, BAD_START},
        {CH_LF, 1'b0, NO_RESULT},    {CH_COLON, 1'b0, NO_RESULT},
        {"0", 1'b0, NO_RESULT},      {"1", 1'b0, NO_RESULT},
        {"F", 1'b0, NO_RESULT},      {"F", 1'b0, NO_RESULT},
        {"F", 1'b0, NO_RESULT},      {"F", 1'b0, NO_RESULT},
        {"0", 1'b0, NO_RESULT},      {"0", 1'b0, NO_RESULT},
        {"a", 1'b0, NO_RESULT},      {"b", 1'b1, TOP_BYTE},
        {"5", 1'b0, NO_RESULT},      {"6", 1'b1, TOP_END},
        {"g", 1'b0, NO_RESULT},      {CH_LF, 1'b0, NO_RESULT},
        {CH_COLON, 1'b0, NO_RESULT}, {"G", 1'b0, NO_RESULT},
        {CH_LF, 1'b0, NO_RESULT}
    };

    // Parser model state and filter setting.
    t_phase      hex_phase;
    logic [1:0]  digit_pos;
    logic [3:0]  hi_nib;
    logic [7:0]  rec_count;
    logic [15:0] rec_addr;
    logic [7:0]  rec_type;
    logic [7:0]  rec_index;
    logic [7:0]  rec_sum;
    logic        filter_data_only;

    t_result     expected_results [$];
    t_char_row   char_tags [$];
    logic [7:0]  line_chars [$];
    int          error_count = 0;
    int          result_count = 0;
    int          chars_sent = 0;
    int          big_records_left = 1;
    bit          burst_line = 1'b0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Value of a hex digit; any other character counts as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]}) return c[3:0];
        if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return c[3:0] + 4'd9;
        return 4'd0;
    endfunction

    // Advance the parser model by one character; returns 1 when a result is due.
    function automatic bit parse_char(input logic [7:0] c, output t_result r);
        logic [3:0] nib;
        logic [7:0] b;
        logic [7:0] total;
        r = '0;
        if (hex_phase == PH_START) begin
            if (c == CH_LF || c == CH_CR || c == CH_SPACE || c == CH_TAB) return 1'b0;
            if (c == CH_SEMI) begin
                hex_phase = PH_SKIP;
                return 1'b0;
            end
            if (c == CH_COLON) begin
                hex_phase = PH_COUNT;
                digit_pos = '0;
                hi_nib    = '0;
                rec_count = '0;
                rec_addr  = '0;
                rec_type  = '0;
                rec_index = '0;
                rec_sum   = '0;
                return 1'b0;
            end
            hex_phase = PH_SKIP;
            r.kind = KIND_ERR;
            return 1'b1;
        end
        if (c == CH_LF) begin
            hex_phase = PH_START;
            return 1'b0;
        end
        if (hex_phase == PH_SKIP) return 1'b0;

        nib = hex_value(c);
        // The address is gathered one digit at a time, summed per byte.
        if (hex_phase == PH_ADDR) begin
            rec_addr = {rec_addr[11:0], nib};
            if (digit_pos[0]) rec_sum = rec_sum + rec_addr[7:0];
            if (digit_pos == 2'd3) begin
                digit_pos = 2'd0;
                hex_phase = PH_TYPE;
            end else begin
                digit_pos = digit_pos + 2'd1;
            end
            return 1'b0;
        end
        if (digit_pos == 2'd0) begin
            hi_nib    = nib;
            digit_pos = 2'd1;
            return 1'b0;
        end
        digit_pos = 2'd0;
        b = {hi_nib, nib};

        case (hex_phase)
            PH_COUNT: begin
                rec_count = b;
                rec_sum   = rec_sum + b;
                hex_phase = PH_ADDR;
            end
            PH_TYPE: begin
                rec_type  = b;
                rec_sum   = rec_sum + b;
                rec_index = 8'd0;
                if (rec_count == 8'd0) hex_phase = PH_CSUM;
                else hex_phase = PH_DATA;
            end
            PH_DATA: begin
                r.kind        = KIND_DATA;
                r.address     = rec_addr + {8'h00, rec_index};
                r.data_byte   = b;
                r.record_type = rec_type;
                r.byte_count  = rec_count;
                rec_sum   = rec_sum + b;
                rec_index = rec_index + 8'd1;
                if (rec_index == rec_count) hex_phase = PH_CSUM;
                return (rec_type == 8'd0) || !filter_data_only;
            end
            default: begin
                total = rec_sum + b;
                hex_phase       = PH_SKIP;
                r.kind          = KIND_END;
                r.address       = rec_addr;
                r.record_type   = rec_type;
                r.byte_count    = rec_count;
                r.checksum_read = b;
                r.checksum_ok   = (total == 8'h00);
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < 40) $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_result(input t_result got, input t_result want);
        if (got.kind !== want.kind)
            report_mismatch($sformatf("result %0d kind %0d, wanted %0d",
                                      result_count, got.kind, want.kind));
        if (got.address !== want.address)
            report_mismatch($sformatf("result %0d address %h, wanted %h",
                                      result_count, got.address, want.address));
        if (got.data_byte !== want.data_byte)
            report_mismatch($sformatf("result %0d data_byte %h, wanted %h",
                                      result_count, got.data_byte, want.data_byte));
        if (got.record_type !== want.record_type)
            report_mismatch($sformatf("result %0d record_type %h, wanted %h",
                                      result_count, got.record_type, want.record_type));
        if (got.byte_count !== want.byte_count)
            report_mismatch($sformatf("result %0d byte_count %h, wanted %h",
                                      result_count, got.byte_count, want.byte_count));
        if (got.checksum_read !== want.checksum_read)
            report_mismatch($sformatf("result %0d checksum_read %h, wanted %h",
                                      result_count, got.checksum_read, want.checksum_read));
        if (got.checksum_ok !== want.checksum_ok)
            report_mismatch($sformatf("result %0d checksum_ok %b, wanted %b",
                                      result_count, got.checksum_ok, want.checksum_ok));
    endtask

    // Model update and result checking, both on the transfers of one edge.
    always @(posedge i_clk) begin
        t_result   got;
        t_result   want;
        t_char_row tag;
        bit        due;
        if (!i_rst_n) begin
            hex_phase        = PH_START;
            digit_pos        = '0;
            hi_nib           = '0;
            rec_count        = '0;
            rec_addr         = '0;
            rec_type         = '0;
            rec_index        = '0;
            rec_sum          = '0;
            filter_data_only = DATA_ONLY_RESET;
        end else begin
            if (cfg_if.valid && cfg_if.ready) filter_data_only = cfg_if.data_only;
            if (char_if.valid && char_if.ready) begin
                due = parse_char(char_if.char_in, want);
                tag = char_tags.pop_front();
                if (tag.typed) expected_results = {expected_results, tag.want};
                else if (due) expected_results = {expected_results, want};
            end
            if (res_if.valid && res_if.ready) begin
                got = {res_if.kind, res_if.address, res_if.data_byte, res_if.record_type,
                       res_if.byte_count, res_if.checksum_read, res_if.checksum_ok};
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d not expected: %h",
                                              result_count, got));
                end else begin
                    compare_result(got, expected_results.pop_front());
                end
                result_count++;
            end
        end
    end

    // Gap length: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, with stretches of steady ready.
    initial begin
        int stall;
        res_if.ready <= 1'b0;
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            if ($urandom_range(0, 4) == 0) repeat ($urandom_range(20, 60)) @(posedge i_clk);
            else repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    end

    // Send one character; valid stays high afterward until the caller drops it.
    task automatic send_char(input logic [7:0] c, input logic typed, input t_result want);
        int        gap;
        t_char_row row;
        gap = burst_line ? 0 : pick_gap();
        if (gap > 0) begin
            char_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        row.c     = c;
        row.typed = typed;
        row.want  = want;
        char_tags = {char_tags, row};
        char_if.valid   <= 1'b1;
        char_if.char_in <= c;
        do @(posedge i_clk); while (!char_if.ready);
        chars_sent++;
    endtask

    // Hold off the character stream until every outstanding result is in.
    task automatic drain_results();
        char_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_data_only(input logic v);
        cfg_if.valid     <= 1'b1;
        cfg_if.data_only <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Any character but line feed.
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        return (c == CH_LF) ? 8'h7E : c;
    endfunction

    // Append one character to the line under construction.
    function automatic void add_char(input logic [7:0] c);
        line_chars = {line_chars, c};
    endfunction

    // Two hex digits in random case; a mangled byte may carry non-hex digits.
    function automatic void push_hex_byte(input logic [7:0] b, input bit mangle);
        logic [3:0] n;
        for (int i = 1; i >= 0; i--) begin
            n = (i == 1) ? b[7:4] : b[3:0];
            if (mangle && $urandom_range(0, 9) == 0) add_char(text_char());
            else if (n < 4'd10) add_char(8'h30 + {4'h0, n});
            else if ($urandom_range(0, 1) == 1) add_char(8'h37 + {4'h0, n});
            else add_char(8'h57 + {4'h0, n});
        end
    endfunction

    // Build one random line into line_chars, ending with a line feed.
    task automatic build_line();
        int         sel;
        int         cnt;
        int         cut;
        logic [15:0] addr;
        logic [7:0] typ;
        logic [7:0] sum;
        logic [7:0] b;
        bit         mangle;
        line_chars.delete();
        sel = $urandom_range(0, 99);
        if (sel < 72) begin
            // Record with random content; some are corrupted or cut short.
            case ($urandom_range(0, 5))
                0: add_char(CH_SPACE);
                1: add_char(CH_TAB);
                2: add_char(CH_CR);
                default: ;
            endcase
            add_char(CH_COLON);
            sel = $urandom_range(0, 99);
            if (sel < 6) cnt = 0;
            else if (sel < 88) cnt = $urandom_range(1, 8);
            else if (sel < 98 || big_records_left == 0) cnt = $urandom_range(9, 32);
            else begin
                cnt = 255;
                big_records_left--;
            end
            sel = $urandom_range(0, 99);
            if (sel < 15) addr = 16'hFFFF - 16'($urandom_range(0, 3));
            else if (sel < 25) addr = 16'h0000;
            else addr = 16'($urandom_range(0, 65535));
            sel = $urandom_range(0, 99);
            if (sel < 70) typ = 8'h00;
            else if (sel < 94) typ = 8'($urandom_range(1, 5));
            else typ = 8'($urandom_range(6, 255));
            mangle = ($urandom_range(0, 9) == 0);
            sum = cnt[7:0] + addr[15:8] + addr[7:0] + typ;
            push_hex_byte(cnt[7:0], mangle);
            push_hex_byte(addr[15:8], mangle);
            push_hex_byte(addr[7:0], mangle);
            push_hex_byte(typ, mangle);
            for (int i = 0; i < cnt; i++) begin
                b = 8'($urandom_range(0, 255));
                sum = sum + b;
                push_hex_byte(b, mangle);
            end
            if ($urandom_range(0, 6) == 0) b = 8'($urandom_range(0, 255));
            else b = 8'h00 - sum;
            push_hex_byte(b, mangle);
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 4)) add_char(text_char());
            end
            if ($urandom_range(0, 11) == 0) begin
                cut = $urandom_range(1, line_chars.size() - 1);
                while (line_chars.size() > cut) void'(line_chars.pop_back());
            end
            if ($urandom_range(0, 2) == 0) add_char(CH_CR);
        end else if (sel < 80) begin
            add_char(CH_SEMI);
            repeat ($urandom_range(0, 6)) add_char(text_char());
        end else if (sel < 90) begin
            add_char(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 4)) add_char(text_char());
        end else begin
            repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)));
        end
        add_char(CH_LF);
    endtask

    // Stimulus: reset, directed table, then random lines under each filter setting.
    initial begin
        int start_count;
        i_rst_n          <= 1'b0;
        char_if.valid    <= 1'b0;
        char_if.char_in  <= 8'h00;
        cfg_if.valid     <= 1'b0;
        cfg_if.data_only <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            burst_line = (i < 12);
            send_char(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int setting = 0; setting < 4; setting++) begin
            drain_results();
            write_data_only(setting[0]);
            start_count = chars_sent;
            while (chars_sent - start_count < RANDOM_PER_SETTING) begin
                build_line();
                burst_line = ($urandom_range(0, 3) == 0);
                foreach (line_chars[i]) send_char(line_chars[i], 1'b0, NO_RESULT);
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
